FILE: rtl/circular_deque_defines.svh
// Assertion macros shared by the circular deque checker.
// Depends on nothing; included by the checker file only.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, clocked on the rising edge, disabled while dis is high.
`define CDQ_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on the rising edge, disabled while dis is high.
`define CDQ_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cdq_pkg.sv
// Shared types, constants and pointer helpers of the circular deque.
// Used by the datapath, the controller, the top level and the checker.
`default_nettype none

package cdq_pkg;

  localparam int DEPTH       = 8;
  localparam int PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W     = $clog2(DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int OCC_W       = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } stat_t;

  function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] ptr);
    return (ptr == '0) ? PTR_W'(DEPTH - 1) : ptr - PTR_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/circular_deque.sv
// Circular double-ended queue on a ring store of eight signed 32-bit words.
// Each request passes three steps from acceptance to its result in the output
// register: capture, store access, result load. A new request is accepted only
// after the result of the previous one has been loaded into the output register.
// A held result does not block acceptance of the next request.
// Synchronous active-low reset empties the deque; store contents stay undefined.
`default_nettype none

module circular_deque (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // Fields from bit 0: operation[1:0], push_value[33:2], zero fill [39:34].
  input  wire logic [cdq_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // Fields from bit 0: pop_value[31:0], status[33:32], occupancy[37:34],
  // is_empty[38], is_full[39].
  output logic      [cdq_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  cdq_pkg::cmd_t  cmd;
  cdq_pkg::stat_t stat;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .stat      (stat),
    .in_tready (in_tready),
    .cmd       (cmd)
  );

  cdq_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/cdq_ram.sv
// Generic single-port RAM with a registered read.
// Depends on nothing; holds the ring store of the circular deque.
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                        wdata,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/cdq_datapath.sv
// Datapath of the circular deque: pointers, count, ring store and result register.
// Depends on cdq_pkg and cdq_ram; driven by commands from cdq_ctrl.
`default_nettype none

module cdq_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire cdq_pkg::cmd_t                      cmd,
  input  wire logic [cdq_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                               out_tready,
  output cdq_pkg::stat_t                          stat,
  output logic                                    out_tvalid,
  output logic      [cdq_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  cdq_pkg::op_t                       op_r;
  logic [cdq_pkg::WORD_W-1:0]         val_r;
  logic [cdq_pkg::PTR_W-1:0]          head_r, head_nxt;
  logic [cdq_pkg::PTR_W-1:0]          tail_r, tail_nxt;
  logic [cdq_pkg::COUNT_W-1:0]        count_r, count_nxt;
  cdq_pkg::status_t                   status_r, status_nxt;
  logic                               pop_ok_r, pop_ok_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [cdq_pkg::OUT_TDATA_W-1:0]    out_data_r, out_data_nxt;

  logic                               ram_we;
  logic                               ram_re;
  logic [cdq_pkg::PTR_W-1:0]          ram_addr;
  logic [cdq_pkg::WORD_W-1:0]         ram_rdata;
  logic                               is_full;
  logic                               is_empty;
  logic [cdq_pkg::WORD_W-1:0]         pop_value;

  assign is_full  = (count_r == cdq_pkg::COUNT_W'(cdq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    pop_ok_nxt = pop_ok_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = head_r;
    if (cmd.exec) begin
      status_nxt = cdq_pkg::ST_DONE;
      pop_ok_nxt = 1'b0;
      case (op_r)
        cdq_pkg::OP_PUSH_REAR: begin
          if (is_full) begin
            status_nxt = cdq_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = tail_r;
            tail_nxt  = cdq_pkg::step_up(tail_r);
            count_nxt = count_r + cdq_pkg::COUNT_W'(1);
          end
        end
        cdq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = cdq_pkg::ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = cdq_pkg::step_down(head_r);
            head_nxt  = cdq_pkg::step_down(head_r);
            count_nxt = count_r + cdq_pkg::COUNT_W'(1);
          end
        end
        cdq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_re     = 1'b1;
            ram_addr   = head_r;
            head_nxt   = cdq_pkg::step_up(head_r);
            count_nxt  = count_r - cdq_pkg::COUNT_W'(1);
            pop_ok_nxt = 1'b1;
          end
        end
        cdq_pkg::OP_POP_REAR: begin
          if (is_empty) begin
            status_nxt = cdq_pkg::ST_EMPTY;
          end else begin
            ram_re     = 1'b1;
            ram_addr   = cdq_pkg::step_down(tail_r);
            tail_nxt   = cdq_pkg::step_down(tail_r);
            count_nxt  = count_r - cdq_pkg::COUNT_W'(1);
            pop_ok_nxt = 1'b1;
          end
        end
        default: begin
          status_nxt = cdq_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign pop_value = pop_ok_r ? ram_rdata : '0;

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {is_full, is_empty, cdq_pkg::OCC_W'(count_r), status_r, pop_value};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= cdq_pkg::op_t'(in_tdata[1:0]);
      val_r <= in_tdata[cdq_pkg::WORD_W+1:2];
    end
    status_r   <= status_nxt;
    pop_ok_r   <= pop_ok_nxt;
    out_data_r <= out_data_nxt;
  end

  cdq_ram #(
    .WIDTH (cdq_pkg::WORD_W),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (val_r),
    .rdata (ram_rdata)
  );

  assign stat.out_stall = out_valid_r && !out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/cdq_ctrl.sv
// Controller of the circular deque: sequences accept, execute and result load.
// Depends on cdq_pkg; drives the datapath through a command struct.
`default_nettype none

module cdq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire cdq_pkg::stat_t stat,
  output logic                in_tready,
  output cdq_pkg::cmd_t       cmd
);

  cdq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    case (state_r)
      cdq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = cdq_pkg::S_EXEC;
        end
      end
      cdq_pkg::S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = cdq_pkg::S_FINISH;
      end
      cdq_pkg::S_FINISH: begin
        if (!stat.out_stall) begin
          cmd.load  = 1'b1;
          state_nxt = cdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/cdq_checker.sv
// Port-level checker of the circular deque, bound to the top level.
// Depends on cdq_pkg and the macros in circular_deque_defines.svh.
`default_nettype none
`include "circular_deque_defines.svh"

module cdq_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [cdq_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  `CDQ_ASSERT_NEXT(a_reset_no_result, clk, 1'b0, !rst_n, !out_tvalid,
    "result after reset")
  `CDQ_ASSERT_NEXT(a_stall_holds, clk, !rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata), "stalled result changed")
  `CDQ_ASSERT_NOW(a_empty_flag, clk, !rst_n, out_tvalid,
    out_tdata[38] == (out_tdata[37:34] == '0), "empty flag disagrees with occupancy")
  `CDQ_ASSERT_NOW(a_full_flag, clk, !rst_n, out_tvalid,
    out_tdata[39] == (out_tdata[37:34] == cdq_pkg::OCC_W'(cdq_pkg::DEPTH)),
    "full flag disagrees with occupancy")
  `CDQ_ASSERT_NOW(a_refused_pop, clk, !rst_n,
    out_tvalid && (out_tdata[33:32] == cdq_pkg::ST_EMPTY),
    out_tdata[38] && (out_tdata[31:0] == '0), "refused pop not empty or nonzero")

endmodule

bind circular_deque cdq_checker u_cdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
